// File: hdl/mrsr_pkg.sv
// package: shared constants, types and codes of the multi-reader slot register
package mrsr_pkg;

  localparam int READERS = 14;
  localparam int NSLOTS  = READERS + 2;
  localparam int SLOT_W  = $clog2(NSLOTS);
  localparam int CNT_W   = $clog2(READERS + 1);
  localparam int RID_W   = 4;
  localparam int DATA_W  = 32;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// File: hdl/mrsr_find.sv
// free-slot search: rotated priority find starting at a base slot
module mrsr_find (
  input  logic [mrsr_pkg::NSLOTS-1:0] free_vec,
  input  mrsr_pkg::slot_t             base,
  output logic                        found,
  output mrsr_pkg::slot_t             idx
);

  localparam int N = mrsr_pkg::NSLOTS;
  localparam int W = mrsr_pkg::SLOT_W;

  mrsr_pkg::slot_t pos [N];
  logic [N-1:0]    rot;

  always_comb begin
    logic [W:0] sum;
    sum = '0;
    for (int i = 0; i < N; i++) begin
      sum = {1'b0, base} + (W+1)'(i);
      if (sum >= (W+1)'(N)) begin
        pos[i] = mrsr_pkg::slot_t'(sum - (W+1)'(N));
      end else begin
        pos[i] = mrsr_pkg::slot_t'(sum);
      end
      rot[i] = free_vec[pos[i]];
    end
  end

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (rot[i]) begin
        found = 1'b1;
        idx   = pos[i];
      end
    end
  end

endmodule

// File: hdl/mrsr_ctrl.sv
// controller: accept and execute state machine
module mrsr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output mrsr_pkg::cmd_t cmd
);

  mrsr_pkg::state_t state;
  mrsr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      mrsr_pkg::ST_IDLE: state_next = start ? mrsr_pkg::ST_EXEC : mrsr_pkg::ST_IDLE;
      mrsr_pkg::ST_EXEC: state_next = mrsr_pkg::ST_IDLE;
      default:           state_next = mrsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    case (state)
      mrsr_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      mrsr_pkg::ST_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/mrsr_dpath.sv
// datapath: slot data, counters, reader table, hint and result registers
module mrsr_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  mrsr_pkg::cmd_t               cmd,
  input  logic                         func,
  input  logic [mrsr_pkg::RID_W-1:0]   reader_id,
  input  logic [mrsr_pkg::DATA_W-1:0]  write_value,
  output logic [mrsr_pkg::SLOT_W-1:0]  slot_index,
  output logic [mrsr_pkg::DATA_W-1:0]  data_out,
  output logic                         fresh,
  output logic                         done
);

  localparam int N = mrsr_pkg::NSLOTS;
  localparam int R = mrsr_pkg::READERS;

  // latched item
  logic                        func_q;
  logic [mrsr_pkg::RID_W-1:0]  rid_q;
  logic [mrsr_pkg::DATA_W-1:0] val_q;

  // register state
  mrsr_pkg::slot_t             cur;
  mrsr_pkg::cnt_t              cur_cnt;
  mrsr_pkg::cnt_t              start_cnt [N];
  mrsr_pkg::cnt_t              end_cnt   [N];
  mrsr_pkg::slot_t             rslot     [R];
  logic                        hint_valid;
  mrsr_pkg::slot_t             hint;
  logic [mrsr_pkg::DATA_W-1:0] slot_data [N];

  logic [N-1:0]    free_vec;
  mrsr_pkg::slot_t cur_succ;
  mrsr_pkg::slot_t base;
  logic            found;
  mrsr_pkg::slot_t found_idx;
  mrsr_pkg::slot_t wslot;
  logic            rd_ok;
  mrsr_pkg::slot_t prev;
  logic            move;
  mrsr_pkg::cnt_t  end_inc;
  logic            do_wr;
  logic            do_move;

  always_comb begin
    for (int s = 0; s < N; s++) begin
      free_vec[s] = (start_cnt[s] == end_cnt[s]) && (mrsr_pkg::slot_t'(s) != cur);
    end
  end

  assign cur_succ = (cur == mrsr_pkg::slot_t'(N - 1)) ? '0 : cur + 1'b1;
  assign base     = hint_valid ? hint : cur_succ;

  mrsr_find u_find (
    .free_vec (free_vec),
    .base     (base),
    .found    (found),
    .idx      (found_idx)
  );

  assign wslot   = found ? found_idx : cur_succ;
  assign rd_ok   = rid_q < mrsr_pkg::RID_W'(R);
  assign prev    = rd_ok ? rslot[rid_q] : '0;
  assign move    = rd_ok && (prev != cur);
  assign end_inc = end_cnt[prev] + 1'b1;
  assign do_wr   = cmd.exec && (func_q == mrsr_pkg::FUNC_WRITE);
  assign do_move = cmd.exec && (func_q == mrsr_pkg::FUNC_READ) && move;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      rid_q  <= reader_id;
      val_q  <= write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= '0;
      cur_cnt    <= mrsr_pkg::cnt_t'(R);
      hint_valid <= 1'b0;
      hint       <= '0;
      for (int s = 0; s < N; s++) begin
        start_cnt[s] <= '0;
        end_cnt[s]   <= '0;
      end
      for (int r = 0; r < R; r++) begin
        rslot[r] <= '0;
      end
    end else if (do_wr) begin
      start_cnt[wslot] <= '0;
      end_cnt[wslot]   <= '0;
      start_cnt[cur]   <= cur_cnt;
      cur              <= wslot;
      cur_cnt          <= '0;
      hint_valid       <= 1'b0;
      hint             <= '0;
    end else if (do_move) begin
      end_cnt[prev] <= end_inc;
      if (end_inc == start_cnt[prev]) begin
        hint_valid <= 1'b1;
        hint       <= prev;
      end
      cur_cnt      <= cur_cnt + 1'b1;
      rslot[rid_q] <= cur;
    end
  end

  // slot 0 holds zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_data[0] <= '0;
    end else if (do_wr) begin
      slot_data[wslot] <= val_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (func_q == mrsr_pkg::FUNC_WRITE) begin
        slot_index <= wslot;
        data_out   <= val_q;
        fresh      <= 1'b0;
      end else begin
        slot_index <= cur;
        data_out   <= slot_data[cur];
        fresh      <= move;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

endmodule

// File: hdl/multi_reader_slot_register.sv
// top level: wait-free single-writer multi-reader slot register
// an item is accepted when start is high and busy is low; busy is then high for one cycle
// while the free-slot search and the state update run; the result shows with done in the
// cycle after that, and a new item can be accepted while that result shows
// reset clears the controller, makes slot 0 current with zero data and counts all readers on it
module multi_reader_slot_register (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func,
  input  logic [mrsr_pkg::RID_W-1:0]   reader_id,
  input  logic [mrsr_pkg::DATA_W-1:0]  write_value,
  output logic [mrsr_pkg::SLOT_W-1:0]  slot_index,
  output logic [mrsr_pkg::DATA_W-1:0]  data_out,
  output logic                         fresh,
  output logic                         done
);

  mrsr_pkg::cmd_t cmd;

  mrsr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  mrsr_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (func),
    .reader_id   (reader_id),
    .write_value (write_value),
    .slot_index  (slot_index),
    .data_out    (data_out),
    .fresh       (fresh),
    .done        (done)
  );

endmodule

// File: hdl/mrsr_checker.sv
// checker: port-level timing assertions and bind to the top level
module mrsr_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic func,
  input logic fresh,
  input logic done
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("busy not followed by a single result");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item in execution");

  a_fresh_read: assert property (@(posedge clk) disable iff (rst)
    done && fresh |-> $past(func, 2) == mrsr_pkg::FUNC_READ)
    else $error("fresh flag on a write result");

endmodule

bind multi_reader_slot_register mrsr_checker u_mrsr_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .func  (func),
  .fresh (fresh),
  .done  (done)
);
